// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/upd_pkg.sv
package upd_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_QUERY_MODE = 3'd0;

   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CASE_MASK  = 8'hdf;
   localparam logic [7:0] LETTER_OFS = 8'd10;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       truncated;
   } rsp_word_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_OPEN  = 3'b010,
      PH_DIGIT = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] high_digit;
   } dec_state_type;

   function automatic logic [7:0] digit_value(input logic [7:0] d);
      if (d >= CH_A) begin
         return (d & CASE_MASK) - CH_A + LETTER_OFS;
      end
      return d - CH_ZERO;
   endfunction

endpackage

// File: src/url_percent_decoder.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_word (in_byte, in_last)
// rsp     | out       | rsp_valid, rsp_stall | rsp_word (out_byte, out_last, truncated)
// csr     | in        | psel, penable, pready| paddr, pwdata, prdata (query_mode)
//
// One word per cycle sustained while rsp_stall does not hold the result register; a taken
// word that yields a byte goes from the input register through the result register to rsp_word.
// The escape decode is one pass between the input register and the result register.
// Synchronous active-high reset clears valids, escape phase and query_mode.
// The input register keeps taking one word while a result is stalled, then req_stall rises.
module url_percent_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  upd_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output upd_pkg::rsp_word_type               rsp_word,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [upd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [upd_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [upd_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import upd_pkg::*;
`include "assert_macros.svh"

   logic          in_valid_ff, in_valid_in;
   req_word_type  in_word_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_word_type  out_word_ff;
   dec_state_type state_ff, state_in;
   logic          query_mode_ff, query_mode_in;
   logic          advance;
   logic          have;
   rsp_word_type  step_word;
   logic          csr_write;

   upd_step u_step (
      .req_word   (in_word_ff),
      .query_mode (query_mode_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .have       (have),
      .rsp_word   (step_word)
   );

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = have;
      end
   end

   assign csr_write = psel && penable && pwrite && pready;
   assign query_mode_in = (csr_write && paddr == ADDR_QUERY_MODE) ? pwdata[0] : query_mode_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_QUERY_MODE) ?
                   {{(CSR_DATA_W-1){1'b0}}, query_mode_ff} : '0;

   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.phase <= PH_IDLE;
         state_ff.high_digit <= 4'h0;
         query_mode_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         query_mode_ff <= query_mode_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (advance && have) begin
         out_word_ff <= step_word;
      end
   end

   `ASSERT_IMPL(a_trunc_form, clock, reset,
                out_valid_ff && out_word_ff.truncated,
                out_word_ff.out_last && out_word_ff.out_byte == 8'h00)
   `ASSERT_NEXT(a_hold_input, clock, reset,
                in_valid_ff && out_valid_ff && rsp_stall,
                in_valid_ff && $stable(in_word_ff))
   `ASSERT_NEXT(a_last_idle, clock, reset,
                advance && in_word_ff.in_last,
                state_ff.phase == PH_IDLE)

endmodule

// File: src/upd_step.sv
module upd_step (
   input  upd_pkg::req_word_type  req_word,
   input  logic                   query_mode,
   input  upd_pkg::dec_state_type state_cur,
   output upd_pkg::dec_state_type state_next,
   output logic                   have,
   output upd_pkg::rsp_word_type  rsp_word
);
   import upd_pkg::*;

   logic [7:0] b;
   logic [7:0] dv;
   logic [7:0] val;
   logic       have_raw;
   logic       pending;

   always_comb begin
      b = (query_mode && req_word.in_byte == CH_PLUS) ? CH_SPACE : req_word.in_byte;
      dv = digit_value(b);
      val = b;
      have_raw = 1'b0;
      state_next = state_cur;
      case (state_cur.phase)
         PH_OPEN: begin
            if (b == CH_PERCENT) begin
               val = CH_PERCENT;
               have_raw = 1'b1;
               state_next.phase = PH_IDLE;
            end else begin
               state_next.high_digit = dv[3:0];
               state_next.phase = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            val = {state_cur.high_digit, 4'b0000} + dv;
            have_raw = 1'b1;
            state_next.phase = PH_IDLE;
         end
         default: begin
            if (b == CH_PERCENT) begin
               state_next.phase = PH_OPEN;
            end else begin
               have_raw = 1'b1;
               state_next.phase = PH_IDLE;
            end
         end
      endcase

      pending = req_word.in_last && (state_next.phase != PH_IDLE);
      if (req_word.in_last) begin
         state_next.phase = PH_IDLE;
      end

      if (pending) begin
         have = 1'b1;
         rsp_word.out_byte = 8'h00;
         rsp_word.out_last = 1'b1;
         rsp_word.truncated = 1'b1;
      end else begin
         have = have_raw;
         rsp_word.out_byte = val;
         rsp_word.out_last = req_word.in_last;
         rsp_word.truncated = 1'b0;
      end
   end

endmodule
